// File: sv/gdrc_pkg.sv
// Shared types, constants and register codes of the grid ray caster.
package gdrc_pkg;

	// Default sizes
	localparam int GRID_SIZE_DEF  = 32;
	localparam int STEP_LIMIT_DEF = 100;

	// Fixed-point constants
	localparam logic [16:0] ONE_Q16    = 17'd65536;
	localparam logic [24:0] MIN_CORR   = 25'd655;
	localparam logic [16:0] MIN_BRIGHT = 17'd13107;
	localparam logic [23:0] DIST_MAX   = 24'hFFFFFF;
	localparam logic [15:0] HEIGHT_MAX = 16'hFFFF;

	// Configuration port
	localparam int CFG_W = 24;
	typedef enum logic [1:0] {
		CFG_SCREEN_HEIGHT = 2'd0,
		CFG_FADE_DISTANCE = 2'd1,
		CFG_FACE_COLOR_X  = 2'd2,
		CFG_FACE_COLOR_Y  = 2'd3
	} cfg_idx_t;

	localparam logic [11:0] SCREEN_HEIGHT_RST = 12'd600;
	localparam logic [7:0]  FADE_DISTANCE_RST = 8'd20;
	localparam logic [23:0] FACE_COLOR_X_RST  = 24'd15022389;
	localparam logic [23:0] FACE_COLOR_Y_RST  = 24'd12000284;

	// Operation codes
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_CAST  = 1'b1;

	typedef struct packed {
		logic               opcode;
		logic [4:0]         cell_x;
		logic [4:0]         cell_y;
		logic               cell_solid;
		logic [20:0]        pos_x;
		logic [20:0]        pos_y;
		logic signed [15:0] dir_x;
		logic signed [15:0] dir_y;
		logic [15:0]        cos_offset;
	} in_item_t;

	typedef struct packed {
		logic [23:0]        distance;
		logic [15:0]        wall_height;
		logic signed [15:0] top_row;
		logic signed [15:0] wall_bottom;
		logic               hit_side;
		logic [7:0]         shade_red;
		logic [7:0]         shade_green;
		logic [7:0]         shade_blue;
	} out_item_t;

endpackage

// File: sv/gdrc_div.sv
// Restoring divider, one quotient bit per cycle.
module gdrc_div #(
	parameter int DW = 39,
	parameter int VW = 25
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [VW-1:0] divisor,
	output logic          done,
	output logic [DW-1:0] quotient
);

	localparam int CNW = $clog2(DW + 1);

	logic          busy_q;
	logic          done_q;
	logic [CNW-1:0] cnt_q;
	logic [VW-1:0] rem_q;
	logic [VW-1:0] d_q;
	logic [DW-1:0] q_q;
	logic [VW:0]   trial;
	logic          ge;

	// Trial subtraction
	assign trial = {rem_q, q_q[DW-1]};
	assign ge    = trial >= {1'b0, d_q};

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNW'(DW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			d_q   <= divisor;
			q_q   <= dividend;
		end else if (busy_q) begin
			rem_q <= ge ? VW'(trial - {1'b0, d_q}) : trial[VW-1:0];
			q_q   <= {q_q[DW-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = q_q;

endmodule

// File: sv/grid_dda_ray_caster.sv
// Grid ray caster: cell map, DDA walk, distance, wall height and shading.
// Write transaction: the block stays ready. Cast: each DDA step runs S_MUL1, S_MUL2, S_CHK
// (shared multiplier and grid read), then up to three divider passes, DW = 32 +
// clog2(STEP_LIMIT+1) (39 at defaults), then S_SHR, S_SHG, S_SHB and S_OUT; one pass fewer
// on a miss or a zero divisor. One ray at a time, ready after the result.
// Reset: grid cleared one cell a cycle (GRID_SIZE^2 cells, 1024 at defaults) with item_ready low.
module grid_dda_ray_caster import gdrc_pkg::*; #(
	parameter int GRID_SIZE  = GRID_SIZE_DEF,
	parameter int STEP_LIMIT = STEP_LIMIT_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_ready,
	input  in_item_t         item,
	output logic             result_valid,
	input  logic             result_ready,
	output out_item_t        result,
	input  logic             cfg_we,
	input  cfg_idx_t         cfg_index,
	input  logic [CFG_W-1:0] cfg_wdata
);

	localparam int GW    = (GRID_SIZE > 1) ? $clog2(GRID_SIZE) : 1;
	localparam int DEPTH = GRID_SIZE * GRID_SIZE;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = ((GW > 5) ? GW : 5) + 2;
	localparam int BW    = 17 + $clog2(STEP_LIMIT + 1);
	localparam int NW    = $clog2(STEP_LIMIT + 1);
	localparam int MA    = (BW > 24) ? BW : 24;
	localparam int MB    = 17;
	localparam int PW    = MA + MB;
	localparam int DW    = BW + 15;
	localparam int VW    = 25;
	localparam logic signed [CW-1:0] GRID_S = CW'(GRID_SIZE);

	typedef enum logic [12:0] {
		S_CLR   = 13'b0000000000001,
		S_IDLE  = 13'b0000000000010,
		S_MUL1  = 13'b0000000000100,
		S_MUL2  = 13'b0000000001000,
		S_CHK   = 13'b0000000010000,
		S_DDIST = 13'b0000000100000,
		S_CORR  = 13'b0000001000000,
		S_HWAIT = 13'b0000010000000,
		S_FWAIT = 13'b0000100000000,
		S_SHR   = 13'b0001000000000,
		S_SHG   = 13'b0010000000000,
		S_SHB   = 13'b0100000000000,
		S_OUT   = 13'b1000000000000
	} state_t;

	state_t state_q;

	// Configuration registers
	logic [11:0] sh_q;
	logic [7:0]  fade_q;
	logic [23:0] colx_q;
	logic [23:0] coly_q;

	// Grid memory
	logic          mem [DEPTH];
	logic [AW-1:0] clr_q;
	logic          mem_we;
	logic [AW-1:0] mem_wa;
	logic          mem_wd;
	logic [AW-1:0] rd_addr;
	logic          rd_q;
	logic          inr_q;

	// Walk state
	logic                 negx_q, negy_q;
	logic [15:0]          ax_q, ay_q;
	logic [BW-1:0]        bx_q, by_q;
	logic signed [CW-1:0] mx_q, my_q;
	logic [NW-1:0]        cnt_q;
	logic                 side_q;
	logic [BW-1:0]        num_q;
	logic [15:0]          den_q;
	logic [PW-1:0]        p_q;
	logic [15:0]          cos_q;

	// Result registers
	logic [23:0]        dist_q;
	logic [15:0]        h_q;
	logic signed [15:0] top_q, bot_q;
	logic [16:0]        bright_q;
	logic [7:0]         shr_q, shg_q, shb_q;

	// Shared multiplier
	logic [MA-1:0] mul_a;
	logic [MB-1:0] mul_b;
	logic [PW-1:0] prod;
	logic [23:0]   col;

	// Shared divider
	logic          div_start;
	logic [DW-1:0] div_dd;
	logic [VW-1:0] div_dv;
	logic          div_done;
	logic [DW-1:0] div_q;

	logic item_acc;
	assign item_acc   = item_valid && item_ready;
	assign item_ready = (state_q == S_IDLE);
	assign col        = side_q ? coly_q : colx_q;

	// Multiplier operand selection
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_MUL1: begin mul_a = MA'(bx_q); mul_b = MB'(ay_q); end
			S_MUL2: begin mul_a = MA'(by_q); mul_b = MB'(ax_q); end
			S_CORR: begin mul_a = MA'(dist_q); mul_b = MB'(cos_q); end
			S_SHR:  begin mul_a = MA'(col[23:16]); mul_b = bright_q; end
			S_SHG:  begin mul_a = MA'(col[15:8]); mul_b = bright_q; end
			S_SHB:  begin mul_a = MA'(col[7:0]); mul_b = bright_q; end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
	end
	assign prod = PW'(mul_a) * PW'(mul_b);

	// DDA step decision
	logic                 crossx;
	logic signed [CW-1:0] nmx, nmy, rx, ry;
	logic                 rin;
	assign crossx  = p_q < prod;
	assign nmx     = mx_q + (negx_q ? {CW{1'b1}} : CW'(1));
	assign nmy     = my_q + (negy_q ? {CW{1'b1}} : CW'(1));
	assign rx      = crossx ? nmx : mx_q;
	assign ry      = crossx ? my_q : nmy;
	assign rin     = (rx >= 0) && (rx < GRID_S) && (ry >= 0) && (ry < GRID_S);
	assign rd_addr = AW'(AW'(ry[GW-1:0]) * AW'(GRID_SIZE) + AW'(rx[GW-1:0]));

	// Post-walk arithmetic
	logic [24:0]        corr;
	logic [7:0]         fade1;
	logic [11:0]        fade10;
	logic [DW-1:0]      drop_dd;
	logic [15:0]        h_n;
	logic signed [18:0] diff, top_n, bot_n;
	logic               solid;

	assign corr    = (prod[39:15] < MIN_CORR) ? MIN_CORR : prod[39:15];
	assign fade1   = (fade_q == 8'd0) ? 8'd1 : fade_q;
	assign fade10  = {1'b0, fade1, 3'b000} + {3'b000, fade1, 1'b0};
	assign drop_dd = DW'({dist_q, 3'b000}) - DW'(dist_q);
	assign h_n     = (|div_q[DW-1:16]) ? HEIGHT_MAX : div_q[15:0];
	assign diff    = $signed({7'b0, sh_q}) - $signed({3'b0, h_n});
	assign top_n   = (diff + $signed({18'b0, diff[18]})) >>> 1;
	assign bot_n   = top_n + $signed({3'b0, h_n});
	assign solid   = !inr_q || rd_q;

	// Divider requests
	always_comb begin
		div_start = 1'b0;
		div_dd    = '0;
		div_dv    = '0;
		case (state_q)
			S_CHK: begin
				div_start = solid && (den_q != 16'd0);
				div_dd    = {num_q, 15'b0};
				div_dv    = VW'(den_q);
			end
			S_CORR: begin
				div_start = 1'b1;
				div_dd    = DW'({sh_q, 16'b0});
				div_dv    = corr;
			end
			S_HWAIT: begin
				div_start = div_done;
				div_dd    = drop_dd;
				div_dv    = VW'(fade10);
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	gdrc_div #(.DW(DW), .VW(VW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dd),
		.divisor  (div_dv),
		.done     (div_done),
		.quotient (div_q)
	);

	// Grid memory write and registered read
	always_comb begin
		mem_we = 1'b0;
		mem_wa = clr_q;
		mem_wd = 1'b0;
		if (state_q == S_CLR) begin
			mem_we = 1'b1;
		end else if (item_acc && item.opcode == OP_WRITE &&
		             int'(item.cell_x) < GRID_SIZE && int'(item.cell_y) < GRID_SIZE) begin
			mem_we = 1'b1;
			mem_wa = AW'(AW'(item.cell_y) * AW'(GRID_SIZE) + AW'(item.cell_x));
			mem_wd = item.cell_solid;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_wa] <= mem_wd;
		rd_q <= mem[rd_addr];
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sh_q   <= SCREEN_HEIGHT_RST;
			fade_q <= FADE_DISTANCE_RST;
			colx_q <= FACE_COLOR_X_RST;
			coly_q <= FACE_COLOR_Y_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SCREEN_HEIGHT: sh_q   <= cfg_wdata[11:0];
				CFG_FADE_DISTANCE: fade_q <= cfg_wdata[7:0];
				CFG_FACE_COLOR_X:  colx_q <= cfg_wdata[23:0];
				CFG_FACE_COLOR_Y:  coly_q <= cfg_wdata[23:0];
				default:           sh_q   <= sh_q;
			endcase
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			clr_q   <= '0;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(DEPTH - 1))
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					cnt_q <= '0;
					if (item_acc && item.opcode == OP_CAST)
						state_q <= S_MUL1;
				end
				S_MUL1: state_q <= S_MUL2;
				S_MUL2: begin
					cnt_q   <= cnt_q + 1'b1;
					state_q <= S_CHK;
				end
				S_CHK: begin
					if (solid)
						state_q <= (den_q != 16'd0) ? S_DDIST : S_CORR;
					else if (cnt_q == NW'(STEP_LIMIT))
						state_q <= S_CORR;
					else
						state_q <= S_MUL1;
				end
				S_DDIST: if (div_done) state_q <= S_CORR;
				S_CORR:  state_q <= S_HWAIT;
				S_HWAIT: if (div_done) state_q <= S_FWAIT;
				S_FWAIT: if (div_done) state_q <= S_SHR;
				S_SHR:   state_q <= S_SHG;
				S_SHG:   state_q <= S_SHB;
				S_SHB:   state_q <= S_OUT;
				S_OUT:   if (result_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Walk and result datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				negx_q <= item.dir_x[15];
				negy_q <= item.dir_y[15];
				ax_q   <= item.dir_x[15] ? 16'(ONE_Q16 - {1'b0, item.dir_x}) : item.dir_x;
				ay_q   <= item.dir_y[15] ? 16'(ONE_Q16 - {1'b0, item.dir_y}) : item.dir_y;
				bx_q   <= item.dir_x[15] ? BW'(item.pos_x[15:0])
				                         : BW'(ONE_Q16 - {1'b0, item.pos_x[15:0]});
				by_q   <= item.dir_y[15] ? BW'(item.pos_y[15:0])
				                         : BW'(ONE_Q16 - {1'b0, item.pos_y[15:0]});
				mx_q   <= $signed({{(CW-5){1'b0}}, item.pos_x[20:16]});
				my_q   <= $signed({{(CW-5){1'b0}}, item.pos_y[20:16]});
				cos_q  <= item.cos_offset;
				dist_q <= '0;
			end
			S_MUL1: p_q <= prod;
			S_MUL2: begin
				inr_q <= rin;
				if (crossx) begin
					num_q  <= bx_q;
					den_q  <= ax_q;
					bx_q   <= bx_q + BW'(ONE_Q16);
					mx_q   <= nmx;
					side_q <= 1'b0;
				end else begin
					num_q  <= by_q;
					den_q  <= ay_q;
					by_q   <= by_q + BW'(ONE_Q16);
					my_q   <= nmy;
					side_q <= 1'b1;
				end
			end
			S_CHK: begin
				if (solid && den_q == 16'd0)
					dist_q <= DIST_MAX;
			end
			S_DDIST: begin
				if (div_done)
					dist_q <= (|div_q[DW-1:24]) ? DIST_MAX : div_q[23:0];
			end
			S_HWAIT: begin
				if (div_done) begin
					h_q   <= h_n;
					top_q <= top_n[15:0];
					bot_q <= (bot_n > 19'sd32767) ? 16'sd32767 : bot_n[15:0];
				end
			end
			S_FWAIT: begin
				if (div_done)
					bright_q <= (div_q >= DW'(ONE_Q16 - MIN_BRIGHT)) ? MIN_BRIGHT
					            : 17'(ONE_Q16 - {1'b0, div_q[15:0]});
			end
			S_SHR:   shr_q <= prod[23:16];
			S_SHG:   shg_q <= prod[23:16];
			S_SHB:   shb_q <= prod[23:16];
			default: p_q   <= p_q;
		endcase
	end

	// Result transaction
	assign result_valid       = (state_q == S_OUT);
	assign result.distance    = dist_q;
	assign result.wall_height = h_q;
	assign result.top_row     = top_q;
	assign result.wall_bottom = bot_q;
	assign result.hit_side    = side_q;
	assign result.shade_red   = shr_q;
	assign result.shade_green = shg_q;
	assign result.shade_blue  = shb_q;

endmodule

// File: sv/gdrc_check.sv
// Port-level checks of the grid ray caster, bound to the top level.
module gdrc_check import gdrc_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             item_valid,
	input logic             item_ready,
	input in_item_t         item,
	input logic             result_valid,
	input logic             result_ready,
	input out_item_t        result
);

	// One ray at a time: no new transaction while a result waits
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(item_ready && result_valid))
		else $error("item_ready high while a result is pending");

	// A write transaction leaves the block ready next cycle
	a_write: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && item_ready && item.opcode == OP_WRITE) |=> item_ready)
		else $error("write transaction stalled the block");

	// A cast transaction makes the block busy
	a_cast: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && item_ready && item.opcode == OP_CAST) |=> !item_ready)
		else $error("block ready straight after a cast");

	// One result per cast
	a_once: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_ready) |=> !result_valid)
		else $error("result repeated");

	// A pending result holds its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result_ready) |=> (result_valid && $stable(result)))
		else $error("pending result changed");

endmodule

bind grid_dda_ray_caster gdrc_check u_gdrc_check (.*);

// File: sim/tb_grid_dda_ray_caster.sv
// Self-checking testbench of the grid ray caster: random and directed casts and cell writes.
module tb_grid_dda_ray_caster;
	import gdrc_pkg::*;

	localparam int GSZ       = 32;
	localparam int STEPS_MAX = 100;
	localparam int N_RAND    = 1450;
	localparam longint CYCLE_LIMIT = 3000000;
	localparam longint LEN_MAX     = 64'hFFFFFF;

	// Predicted block state
	bit              map_cells [GSZ*GSZ];
	logic [11:0]     rows_cfg;
	logic [7:0]      fade_cfg;
	logic [23:0]     colour_x_cfg;
	logic [23:0]     colour_y_cfg;
	int              n_errors;

	// DDA walk plus height and shading for one cast transaction
	function automatic out_item_t cast_ray(in_item_t it);
		out_item_t r;
		bit negx, negy, side;
		longint ax, ay, bx, by, num, den, ray_len, corr, h, fade, drop;
		int mx, my, top, bot;
		logic [23:0] colour;
		longint bright;
		negx = it.dir_x[15];
		negy = it.dir_y[15];
		ax = negx ? 65536 - longint'(it.dir_x[15:0]) : longint'(it.dir_x[15:0]);
		ay = negy ? 65536 - longint'(it.dir_y[15:0]) : longint'(it.dir_y[15:0]);
		mx = int'(it.pos_x[20:16]);
		my = int'(it.pos_y[20:16]);
		bx = negx ? longint'(it.pos_x[15:0]) : 65536 - longint'(it.pos_x[15:0]);
		by = negy ? longint'(it.pos_y[15:0]) : 65536 - longint'(it.pos_y[15:0]);
		side = 0;
		ray_len = 0;
		for (int s = 0; s < STEPS_MAX; s++) begin
			if (bx * ay < by * ax) begin
				num = bx; den = ax; bx += 65536; mx += negx ? -1 : 1; side = 0;
			end else begin
				num = by; den = ay; by += 65536; my += negy ? -1 : 1; side = 1;
			end
			if (mx < 0 || my < 0 || mx >= GSZ || my >= GSZ || map_cells[my*GSZ+mx]) begin
				if (den == 0) ray_len = LEN_MAX;
				else begin
					ray_len = (num * 32768) / den;
					if (ray_len > LEN_MAX) ray_len = LEN_MAX;
				end
				break;
			end
		end
		corr = (ray_len * longint'(it.cos_offset)) >> 15;
		if (corr < 655) corr = 655;
		h = (longint'(rows_cfg) << 16) / corr;
		if (h > 65535) h = 65535;
		top = (int'(rows_cfg) - int'(h)) / 2;
		bot = top + int'(h);
		if (bot > 32767) bot = 32767;
		fade = (fade_cfg == 8'd0) ? longint'(1) : longint'(fade_cfg);
		drop = (ray_len * 7) / (10 * fade);
		bright = (drop >= 65536 - 13107) ? 13107 : 65536 - drop;
		colour = side ? colour_y_cfg : colour_x_cfg;
		r.distance    = ray_len[23:0];
		r.wall_height = h[15:0];
		r.top_row     = top[15:0];
		r.wall_bottom = bot[15:0];
		r.hit_side    = side;
		r.shade_red   = 8'((longint'(colour[23:16]) * bright) >> 16);
		r.shade_green = 8'((longint'(colour[15:8]) * bright) >> 16);
		r.shade_blue  = 8'((longint'(colour[7:0]) * bright) >> 16);
		return r;
	endfunction

	// Scoreboard: turns accepted transactions into expected results
	class ray_scoreboard;
		out_item_t pending_rays[$];

		function void note_item(in_item_t it);
			if (it.opcode == OP_WRITE)
				map_cells[int'(it.cell_y)*GSZ + int'(it.cell_x)] = it.cell_solid;
			else
				pending_rays.push_back(cast_ray(it));
		endfunction

		function void check_result(out_item_t got);
			out_item_t exp_r;
			if (pending_rays.size() == 0) begin
				$display("%0t: unexpected result %h", $time, got);
				n_errors++;
				return;
			end
			exp_r = pending_rays.pop_front();
			if (got.distance !== exp_r.distance)
				$display("%0t: distance exp %h got %h", $time, exp_r.distance, got.distance);
			if (got.wall_height !== exp_r.wall_height)
				$display("%0t: wall_height exp %h got %h", $time,
					exp_r.wall_height, got.wall_height);
			if (got.top_row !== exp_r.top_row)
				$display("%0t: top_row exp %h got %h", $time, exp_r.top_row, got.top_row);
			if (got.wall_bottom !== exp_r.wall_bottom)
				$display("%0t: wall_bottom exp %h got %h", $time,
					exp_r.wall_bottom, got.wall_bottom);
			if (got.hit_side !== exp_r.hit_side)
				$display("%0t: hit_side exp %h got %h", $time, exp_r.hit_side, got.hit_side);
			if ({got.shade_red, got.shade_green, got.shade_blue} !==
					{exp_r.shade_red, exp_r.shade_green, exp_r.shade_blue})
				$display("%0t: shade exp %h got %h", $time,
					{exp_r.shade_red, exp_r.shade_green, exp_r.shade_blue},
					{got.shade_red, got.shade_green, got.shade_blue});
			if (got !== exp_r) n_errors++;
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             item_valid;
	logic             item_ready;
	in_item_t         item;
	logic             result_valid;
	logic             result_ready;
	out_item_t        result;
	logic             cfg_we;
	cfg_idx_t         cfg_index;
	logic [CFG_W-1:0] cfg_wdata;

	ray_scoreboard sb;
	bit            calm;
	longint        cycle_count;

	grid_dda_ray_caster u_dut (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_ready(item_ready), .item(item),
		.result_valid(result_valid), .result_ready(result_ready), .result(result),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Monitor: note inputs and check results at the accepting edge
	always @(posedge clk) begin
		if (arst_n && item_valid && item_ready) sb.note_item(item);
		if (arst_n && result_valid && result_ready) sb.check_result(result);
	end

	// Result side back-pressure in bursts
	initial begin
		int n;
		result_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (!calm && $urandom_range(0, 3) == 0) begin
				n = int'($urandom_range(1, 17));
				result_ready <= 1'b0;
				repeat (n) @(posedge clk);
			end else begin
				n = int'($urandom_range(1, 30));
				result_ready <= 1'b1;
				repeat (n) @(posedge clk);
			end
		end
	end

	// Valid stays high after acceptance until the next item or a drain lowers it
	task automatic send_item(in_item_t it);
		if (!calm && $urandom_range(0, 4) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		item_valid <= 1'b1;
		item       <= it;
		@(posedge clk);
		while (!item_ready) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [CFG_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_SCREEN_HEIGHT: rows_cfg     = val[11:0];
			CFG_FADE_DISTANCE: fade_cfg     = val[7:0];
			CFG_FACE_COLOR_X:  colour_x_cfg = val;
			default:           colour_y_cfg = val;
		endcase
		@(posedge clk);
	endtask

	// Wait for all results, then a latency margin so the block is idle
	task automatic drain();
		item_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending_rays.size() != 0) @(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	function automatic in_item_t write_cell(int x, int y, bit solid);
		in_item_t it;
		it = '0;
		it.opcode = OP_WRITE;
		it.cell_x = 5'(x); it.cell_y = 5'(y); it.cell_solid = solid;
		it.pos_x = 21'($urandom); it.pos_y = 21'($urandom);
		return it;
	endfunction

	function automatic in_item_t make_ray(logic [20:0] px, logic [20:0] py,
			logic [15:0] dx, logic [15:0] dy, logic [15:0] c);
		in_item_t it;
		it = '0;
		it.opcode = OP_CAST;
		it.cell_x = 5'($urandom); it.cell_y = 5'($urandom);
		it.cell_solid = 1'($urandom);
		it.pos_x = px; it.pos_y = py; it.dir_x = dx; it.dir_y = dy; it.cos_offset = c;
		return it;
	endfunction

	// Random cast from inside the map; some rays start in an edge column or have a zero or near-axis direction
	function automatic in_item_t rand_ray();
		logic [15:0] dx, dy, c;
		logic [20:0] px, py;
		px = 21'($urandom); py = 21'($urandom);
		dx = 16'($urandom); dy = 16'($urandom);
		c  = 16'($urandom_range(0, 32768));
		case ($urandom_range(0, 9))
			0: dx = '0;
			1: dy = '0;
			2: c = 16'($urandom);
			3: begin dx = 16'h8000; dy = 16'($urandom_range(0, 3)); end
			default: ;
		endcase
		if ($urandom_range(0, 7) == 0) begin
			px[20:16] = ($urandom_range(0, 1) != 0) ? 5'd0 : 5'd31;
		end
		return make_ray(px, py, dx, dy, c);
	endfunction

	task automatic rand_config();
		write_reg(CFG_SCREEN_HEIGHT, CFG_W'($urandom_range(0, 4095)));
		write_reg(CFG_FADE_DISTANCE, CFG_W'($urandom_range(0, 255)));
		write_reg(CFG_FACE_COLOR_X, CFG_W'($urandom));
		write_reg(CFG_FACE_COLOR_Y, CFG_W'($urandom));
	endtask

	initial begin
		sb = new();
		n_errors = 0;
		cycle_count = 0;
		calm = 0;
		item_valid = 1'b0;
		item = '0;
		cfg_we = 1'b0;
		cfg_index = CFG_SCREEN_HEIGHT;
		cfg_wdata = '0;
		rows_cfg = 12'd600; fade_cfg = 8'd20;
		colour_x_cfg = 24'd15022389; colour_y_cfg = 24'd12000284;
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: open map, axis rays, zero direction, cosine extremes
		send_item(make_ray({5'd16, 16'h8000}, {5'd16, 16'h8000}, 16'h7FFF, 16'h0000, 16'h8000));
		send_item(make_ray({5'd16, 16'h8000}, {5'd16, 16'h8000}, 16'h8000, 16'h0000, 16'h0000));
		send_item(make_ray({5'd0, 16'h0000}, {5'd0, 16'h0000}, 16'h0000, 16'h7FFF, 16'hFFFF));
		send_item(make_ray({5'd31, 16'hFFFF}, {5'd31, 16'hFFFF}, 16'h0000, 16'h0000, 16'h8000));
		send_item(make_ray(21'h1FFFFF, 21'h0, 16'h0001, 16'h8000, 16'h4000));
		// Walls (no write can fall outside the map: fields are 5 bits), rays at them, one wall cleared
		send_item(write_cell(17, 16, 1));
		send_item(write_cell(0, 0, 1));
		send_item(write_cell(31, 31, 1));
		send_item(make_ray({5'd16, 16'h8000}, {5'd16, 16'h8000}, 16'h7FFF, 16'h0001, 16'h8000));
		send_item(make_ray({5'd16, 16'h0000}, {5'd16, 16'h0000}, 16'h5A82, 16'h5A82, 16'h7000));
		send_item(make_ray({5'd16, 16'h0001}, {5'd16, 16'h0001}, 16'h0001, 16'h0001, 16'h8000));
		send_item(make_ray({5'd1, 16'h0}, {5'd1, 16'h0}, 16'hA57E, 16'hA57E, 16'h8000));
		send_item(write_cell(17, 16, 0));
		send_item(make_ray({5'd16, 16'h8000}, {5'd16, 16'h8000}, 16'h7FFF, 16'h0001, 16'h8000));
		drain();

		// Register extremes
		write_reg(CFG_SCREEN_HEIGHT, '0);
		write_reg(CFG_FADE_DISTANCE, '0);
		write_reg(CFG_FACE_COLOR_X, 24'hFFFFFF);
		write_reg(CFG_FACE_COLOR_Y, 24'h000000);
		send_item(make_ray({5'd5, 16'h0}, {5'd5, 16'h0}, 16'h7FFF, 16'h0, 16'h8000));
		send_item(make_ray({5'd5, 16'h0}, {5'd5, 16'h0}, 16'h0, 16'h8000, 16'h8000));
		drain();
		write_reg(CFG_SCREEN_HEIGHT, 24'd4095);
		write_reg(CFG_FADE_DISTANCE, 24'd255);
		write_reg(CFG_FACE_COLOR_X, 24'h000000);
		write_reg(CFG_FACE_COLOR_Y, 24'hFFFFFF);
		send_item(make_ray({5'd30, 16'hFFFF}, {5'd2, 16'h0}, 16'h0003, 16'h7FFF, 16'h0001));
		send_item(make_ray({5'd3, 16'h0}, {5'd3, 16'h0}, 16'h0, 16'h7FFF, 16'h8000));
		drain();

		// Random phases: sparse maze writes and casts
		for (int ph = 0; ph < 6; ph++) begin
			if (ph == 5) calm = 1;
			if (ph == 1) begin
				write_reg(CFG_SCREEN_HEIGHT, 24'd1);
				write_reg(CFG_FADE_DISTANCE, 24'd1);
				write_reg(CFG_FACE_COLOR_X, 24'hE53935);
				write_reg(CFG_FACE_COLOR_Y, 24'hB71C1C);
			end else if (ph != 0) rand_config();
			for (int i = 0; i < N_RAND / 6; i++) begin
				if ($urandom_range(0, 2) == 0)
					send_item(write_cell(int'($urandom_range(0, 31)),
						int'($urandom_range(0, 31)), $urandom_range(0, 3) == 0));
				else
					send_item(rand_ray());
			end
			drain();
		end

		if (n_errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule
